FILE: hw/rtl/led_ring_animation_engine_unit_macros.svh
// assertion macros shared by the led ring animation engine rtl
`ifndef LED_RING_ANIMATION_ENGINE_UNIT_MACROS_SVH
`define LED_RING_ANIMATION_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge out of reset
`define LRAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrae: same-cycle check failed");
// next-cycle implication
`define LRAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrae: next-cycle check failed");
`else
`define LRAE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/lrae_pkg.sv
// shared types and constants of the led ring animation engine
package lrae_pkg;

    localparam int LRAE_NUM_LEDS = 16;
    localparam int PIXEL_W       = 24;
    localparam int FRAME_RATE    = 85;

    localparam logic [7:0] BLINK_STEP      = 8'(255 / FRAME_RATE);
    localparam logic [3:0] COLOR_LIMIT_RST = 4'd8;

    // command codes
    localparam logic [1:0] CMD_SOLID = 2'd0;
    localparam logic [1:0] CMD_BLINK = 2'd1;
    localparam logic [1:0] CMD_SPIN  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // channel numbers, pixel byte lanes are g, r, b from the low end
    localparam logic [1:0] CH_G    = 2'd0;
    localparam logic [1:0] CH_R    = 2'd1;
    localparam logic [1:0] CH_B    = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    // per-pixel operation applied during a frame walk
    typedef enum logic [2:0] {
        OP_PASS,
        OP_SOLID,
        OP_CLEAR,
        OP_BLINK_UP,
        OP_BLINK_DOWN,
        OP_RAMP,
        OP_ROTATE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] ref_mask;
        logic [1:0] prim;
        logic [1:0] sec;
        logic [7:0] grad;
        logic       rot_inc;
    } t_alu_ctrl;

    typedef struct packed {
        logic any_full;
        logic lit_zero;
        logic prim_full;
        logic sec_zero;
    } t_alu_flags;

endpackage

FILE: hw/rtl/lrae_cmd_if.sv
// command channel: one command and color per transaction
interface lrae_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] color;

    modport source (output valid, output cmd, output color, input ready);
    modport sink (input valid, input cmd, input color, output ready);
endinterface

FILE: hw/rtl/lrae_res_if.sv
// result channel: one pixel or one error per transaction
interface lrae_res_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output status, output led_index, output red,
                    output green, output blue, output last, input ready);
    modport sink (input valid, input status, input led_index, input red,
                  input green, input blue, input last, output ready);
endinterface

FILE: hw/rtl/lrae_cfg_if.sv
// configuration write channel for the color limit register
interface lrae_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] color_limit;

    modport source (output valid, output color_limit, input ready);
    modport sink (input valid, input color_limit, output ready);
endinterface

FILE: hw/rtl/lrae_frame_store.sv
// frame memory: one pixel per led, registered read, valid bits give the zero reset
module lrae_frame_store import lrae_pkg::*; #(
    parameter int  DEPTH = LRAE_NUM_LEDS,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [PIXEL_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [PIXEL_W-1:0] o_rd_data
);

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic [PIXEL_W-1:0] r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: hw/rtl/lrae_pixel_alu.sv
// pixel update: fill, clear, blink ramp, spin ramp and rotation of one pixel
module lrae_pixel_alu import lrae_pkg::*; (
    input  logic [PIXEL_W-1:0] i_px,
    input  t_alu_ctrl          i_ctrl,
    output logic [PIXEL_W-1:0] o_px,
    output t_alu_flags         o_flags
);

    logic [7:0] w_old [4];
    logic [7:0] w_new [4];
    logic [7:0] w_room;
    logic [7:0] w_np;

    assign w_old[0] = i_px[7:0];
    assign w_old[1] = i_px[15:8];
    assign w_old[2] = i_px[23:16];
    assign w_old[3] = 8'd0;

    assign w_room = 8'd255 - i_ctrl.grad;
    assign w_np   = w_old[i_ctrl.prim] + BLINK_STEP;

    always_comb begin
        w_new = w_old;
        case (i_ctrl.op)
            OP_PASS: begin
            end
            OP_SOLID: begin
                for (int c = 0; c < 3; c++) begin
                    w_new[c] = i_ctrl.ref_mask[c] ? 8'hFF : 8'h00;
                end
            end
            OP_CLEAR: begin
                for (int c = 0; c < 3; c++) begin
                    w_new[c] = 8'h00;
                end
            end
            OP_BLINK_UP: begin
                for (int c = 0; c < 3; c++) begin
                    if (i_ctrl.ref_mask[c]) begin
                        w_new[c] = w_old[c] + BLINK_STEP;
                    end
                end
            end
            OP_BLINK_DOWN: begin
                for (int c = 0; c < 3; c++) begin
                    if (i_ctrl.ref_mask[c]) begin
                        w_new[c] = w_old[c] - BLINK_STEP;
                    end
                end
            end
            OP_RAMP: begin
                w_new[i_ctrl.prim] = w_np;
                // overflow past the gradient headroom spills into the secondary
                if (w_np > w_room) begin
                    w_new[i_ctrl.sec] = w_np - w_room;
                end
            end
            OP_ROTATE: begin
                w_new[i_ctrl.sec] = i_ctrl.rot_inc ? w_old[i_ctrl.sec] + 8'd1
                                                   : w_old[i_ctrl.sec] - 8'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_px = {w_new[2], w_new[1], w_new[0]};

    assign o_flags.any_full  = (w_new[0] == 8'hFF) || (w_new[1] == 8'hFF) ||
                               (w_new[2] == 8'hFF);
    assign o_flags.lit_zero  = (i_ctrl.ref_mask[0] && w_new[0] == 8'h00) ||
                               (i_ctrl.ref_mask[1] && w_new[1] == 8'h00) ||
                               (i_ctrl.ref_mask[2] && w_new[2] == 8'h00);
    assign o_flags.prim_full = (w_new[i_ctrl.prim] == 8'hFF);
    assign o_flags.sec_zero  = (w_new[i_ctrl.sec] == 8'h00);

endmodule

FILE: hw/rtl/led_ring_animation_engine_unit.sv
// top level of the led ring animation engine: command decode and frame walk sequencer
//
// The engine keeps a frame of NUM_LEDS pixels in a small synchronous memory and
// handles four commands: solid fills the frame with the commanded color, blink and
// spin clear it and start an animation, and tick advances the running animation by
// one frame. Every frame command walks the whole frame in led order: each pixel is
// read, updated and written back, and sent out as one result transaction with its
// led index, last being set on the final led. When the result side never stalls,
// the command is decoded into registers, the frame memory read is registered, and
// the walk moves one pixel per cycle through the single read/write port. A color at
// or above the color limit register gives a single error transaction (status 1,
// last 1), and a spin of the color already spinning gives no result at all. The
// color limit register may be written only while the engine is idle, and takes
// effect on the next command. After reset the frame is dark, no animation runs
// and the color limit is 8, so every color is accepted.
`include "led_ring_animation_engine_unit_macros.svh"

module led_ring_animation_engine_unit import lrae_pkg::*; #(
    parameter int NUM_LEDS = LRAE_NUM_LEDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrae_cmd_if.sink   i_cmd,
    lrae_res_if.source o_res,
    lrae_cfg_if.sink   i_cfg
);

    localparam int IDX_W     = $clog2(NUM_LEDS);
    localparam int CNT_W     = $clog2(NUM_LEDS + 1);
    localparam int HALF      = NUM_LEDS / 2;
    localparam int SPIN_STEP = 255 / (NUM_LEDS / 2) + 1;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef enum logic [2:0] {
        MODE_SOLID,
        MODE_BLINK_UP,
        MODE_BLINK_DOWN,
        MODE_SPIN_UP,
        MODE_SPIN
    } t_mode;

    // control and animation state
    t_state             r_state, n_state;
    logic [3:0]         r_color_limit, n_color_limit;
    t_mode              r_mode, n_mode;
    logic [2:0]         r_ref, n_ref;
    logic [1:0]         r_prim, n_prim;
    logic [1:0]         r_sec, n_sec;
    logic [IDX_W-1:0]   r_rot_point, n_rot_point;
    logic               r_running, n_running;

    // frame walk
    t_op                r_op, n_op;
    logic [IDX_W-1:0]   r_rot_start, n_rot_start;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]   r_mod_idx, n_mod_idx;
    logic               r_rd_pend, n_rd_pend;
    logic [7:0]         r_grad, n_grad;
    logic               r_rot_inc, n_rot_inc;
    logic               r_rot_last, n_rot_last;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;
    logic [5:0]         r_out_idx, n_out_idx;
    logic [7:0]         r_out_red, n_out_red;
    logic [7:0]         r_out_green, n_out_green;
    logic [7:0]         r_out_blue, n_out_blue;
    logic               r_out_last, n_out_last;

    logic               w_out_free;
    logic               w_cmd_acc;
    logic               w_consume;
    logic               w_issue;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_mod_last;
    logic [2:0]         w_px;
    logic               w_bad;
    logic [1:0]         w_pick_prim;
    logic [1:0]         w_pick_sec;
    t_op                w_tick_op;
    logic [IDX_W:0]     w_ofs;
    logic [IDX_W-1:0]   w_kk;
    logic [15:0]        w_prod;
    logic [7:0]         w_grad;
    logic [PIXEL_W-1:0] w_rd_px;
    logic [PIXEL_W-1:0] w_new_px;
    t_alu_ctrl          w_ctrl;
    t_alu_flags         w_flags;

    // terms watched by the checks at the end
    logic               w_tick_acc;
    logic               w_res_end;
    logic               w_res_top;
    logic               w_res_err;
    logic               w_res_dark;

    // handshakes
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_cmd_acc  = i_cmd.valid && (r_state == S_IDLE) && w_out_free;
    assign w_consume  = r_rd_pend && w_out_free;
    assign w_issue    = (r_state == S_WALK) && (r_rd_idx != CNT_W'(NUM_LEDS)) &&
                        (!r_rd_pend || w_consume);
    assign w_rd_addr  = r_rd_idx[IDX_W-1:0];
    assign w_mod_last = (r_mod_idx == IDX_W'(NUM_LEDS - 1));

    assign i_cmd.ready = (r_state == S_IDLE) && w_out_free;
    assign i_cfg.ready = 1'b1;

    // color mask in channel order: green, red, blue from bit 0
    assign w_px  = {i_cmd.color[2], i_cmd.color[0], i_cmd.color[1]};
    assign w_bad = ({1'b0, i_cmd.color} >= r_color_limit);

    // spin channels: a two-channel color ramps the later one of the pair,
    // a single channel gets its successor as gradient, black stays dark
    always_comb begin
        if (w_px[0] && w_px[1]) begin
            w_pick_prim = CH_R;
            w_pick_sec  = CH_G;
        end else if (w_px[1] && w_px[2]) begin
            w_pick_prim = CH_B;
            w_pick_sec  = CH_R;
        end else if (w_px[2] && w_px[0]) begin
            w_pick_prim = CH_G;
            w_pick_sec  = CH_B;
        end else if (w_px[0]) begin
            w_pick_prim = CH_G;
            w_pick_sec  = CH_R;
        end else if (w_px[1]) begin
            w_pick_prim = CH_R;
            w_pick_sec  = CH_B;
        end else if (w_px[2]) begin
            w_pick_prim = CH_B;
            w_pick_sec  = CH_G;
        end else begin
            w_pick_prim = CH_NONE;
            w_pick_sec  = CH_R;
        end
    end

    // what a tick does to each pixel
    always_comb begin
        w_tick_op = OP_PASS;
        if (r_running) begin
            case (r_mode)
                MODE_BLINK_UP:   w_tick_op = OP_BLINK_UP;
                MODE_BLINK_DOWN: w_tick_op = OP_BLINK_DOWN;
                MODE_SPIN_UP:    w_tick_op = (r_prim != CH_NONE) ? OP_RAMP : OP_PASS;
                MODE_SPIN:       w_tick_op = (r_prim != CH_NONE) ? OP_ROTATE : OP_PASS;
                default:         w_tick_op = OP_PASS;
            endcase
        end
    end

    // per-led terms, worked out at read issue and registered with the read
    always_comb begin
        if (w_rd_addr >= r_rot_start) begin
            w_ofs = {1'b0, w_rd_addr} - {1'b0, r_rot_start};
        end else begin
            w_ofs = {1'b0, w_rd_addr} + (IDX_W + 1)'(NUM_LEDS) - {1'b0, r_rot_start};
        end
    end

    assign w_kk   = (w_rd_addr < IDX_W'(HALF)) ? w_rd_addr : w_rd_addr - IDX_W'(HALF);
    assign w_prod = 16'(w_kk) * 16'(SPIN_STEP);
    // rising gradient over the first half, falling over the second, byte wrap
    assign w_grad = (w_rd_addr < IDX_W'(HALF)) ? w_prod[7:0] : 8'd255 - w_prod[7:0];

    // frame memory and pixel update
    lrae_frame_store #(
        .DEPTH (NUM_LEDS)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_consume),
        .i_wr_addr (r_mod_idx),
        .i_wr_data (w_new_px),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_px)
    );

    assign w_ctrl.op       = r_op;
    assign w_ctrl.ref_mask = r_ref;
    assign w_ctrl.prim     = r_prim;
    assign w_ctrl.sec      = r_sec;
    assign w_ctrl.grad     = r_grad;
    assign w_ctrl.rot_inc  = r_rot_inc;

    lrae_pixel_alu u_pixel_alu (
        .i_px    (w_rd_px),
        .i_ctrl  (w_ctrl),
        .o_px    (w_new_px),
        .o_flags (w_flags)
    );

    // next-state logic
    always_comb begin
        n_state       = r_state;
        n_color_limit = r_color_limit;
        n_mode        = r_mode;
        n_ref         = r_ref;
        n_prim        = r_prim;
        n_sec         = r_sec;
        n_rot_point   = r_rot_point;
        n_running     = r_running;
        n_op          = r_op;
        n_rot_start   = r_rot_start;
        n_rd_idx      = r_rd_idx;
        n_mod_idx     = r_mod_idx;
        n_rd_pend     = r_rd_pend;
        n_grad        = r_grad;
        n_rot_inc     = r_rot_inc;
        n_rot_last    = r_rot_last;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_idx     = r_out_idx;
        n_out_red     = r_out_red;
        n_out_green   = r_out_green;
        n_out_blue    = r_out_blue;
        n_out_last    = r_out_last;

        if (i_cfg.valid) begin
            n_color_limit = i_cfg.color_limit;
        end

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        // command decode, the state of solid, blink and spin changes here
        if (w_cmd_acc) begin
            n_rd_idx    = '0;
            n_rd_pend   = 1'b0;
            n_rot_start = r_rot_point;
            if (i_cmd.cmd == CMD_TICK) begin
                n_op    = w_tick_op;
                n_state = S_WALK;
            end else if (w_bad) begin
                // an invalid solid still stops the animation
                if (i_cmd.cmd == CMD_SOLID) begin
                    n_running = 1'b0;
                end
                n_out_valid  = 1'b1;
                n_out_status = 1'b1;
                n_out_idx    = '0;
                n_out_red    = '0;
                n_out_green  = '0;
                n_out_blue   = '0;
                n_out_last   = 1'b1;
            end else begin
                case (i_cmd.cmd)
                    CMD_SOLID: begin
                        n_running = 1'b0;
                        n_op      = OP_SOLID;
                        n_mode    = MODE_SOLID;
                        n_ref     = w_px;
                        n_state   = S_WALK;
                    end
                    CMD_BLINK: begin
                        n_op      = OP_CLEAR;
                        n_mode    = MODE_BLINK_UP;
                        n_running = 1'b1;
                        n_ref     = w_px;
                        n_state   = S_WALK;
                    end
                    CMD_SPIN: begin
                        // spinning the current color again is a no-op
                        if (!(w_px == r_ref &&
                              (r_mode == MODE_SPIN_UP || r_mode == MODE_SPIN))) begin
                            n_prim      = w_pick_prim;
                            n_sec       = w_pick_sec;
                            n_op        = OP_CLEAR;
                            n_mode      = MODE_SPIN_UP;
                            n_rot_point = '0;
                            n_running   = 1'b1;
                            n_ref       = w_px;
                            n_state     = S_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // read side of the walk
        if (w_issue) begin
            n_rd_idx   = r_rd_idx + CNT_W'(1);
            n_mod_idx  = w_rd_addr;
            n_rd_pend  = 1'b1;
            n_grad     = w_grad;
            n_rot_inc  = (w_ofs < (IDX_W + 1)'(HALF));
            n_rot_last = (w_ofs == (IDX_W + 1)'(NUM_LEDS - 1));
        end else if (w_consume) begin
            n_rd_pend = 1'b0;
        end

        // write-back side: pixel goes out, animation state follows it
        if (w_consume) begin
            n_out_valid  = 1'b1;
            n_out_status = 1'b0;
            n_out_idx    = 6'(r_mod_idx);
            n_out_green  = w_new_px[7:0];
            n_out_red    = w_new_px[15:8];
            n_out_blue   = w_new_px[23:16];
            n_out_last   = w_mod_last;
            case (r_op)
                OP_BLINK_UP, OP_BLINK_DOWN: begin
                    // the blink direction follows led 0
                    if (r_mod_idx == '0) begin
                        if (r_op == OP_BLINK_UP && w_flags.any_full) begin
                            n_mode = MODE_BLINK_DOWN;
                        end else if (w_flags.lit_zero) begin
                            n_mode = MODE_BLINK_UP;
                        end
                    end
                end
                OP_RAMP: begin
                    if (w_flags.prim_full) begin
                        n_mode = MODE_SPIN;
                    end
                end
                OP_ROTATE: begin
                    // the led just behind the start moves the start when it goes dark
                    if (r_rot_last && w_flags.sec_zero) begin
                        n_rot_point = r_mod_idx;
                    end
                end
                default: begin
                end
            endcase
            if (w_mod_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_color_limit <= COLOR_LIMIT_RST;
            r_mode        <= MODE_SOLID;
            r_ref         <= '0;
            r_prim        <= '0;
            r_sec         <= '0;
            r_rot_point   <= '0;
            r_running     <= 1'b0;
            r_op          <= OP_PASS;
            r_rot_start   <= '0;
            r_rd_idx      <= '0;
            r_mod_idx     <= '0;
            r_rd_pend     <= 1'b0;
            r_grad        <= '0;
            r_rot_inc     <= 1'b0;
            r_rot_last    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_status  <= 1'b0;
            r_out_idx     <= '0;
            r_out_red     <= '0;
            r_out_green   <= '0;
            r_out_blue    <= '0;
            r_out_last    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_color_limit <= n_color_limit;
            r_mode        <= n_mode;
            r_ref         <= n_ref;
            r_prim        <= n_prim;
            r_sec         <= n_sec;
            r_rot_point   <= n_rot_point;
            r_running     <= n_running;
            r_op          <= n_op;
            r_rot_start   <= n_rot_start;
            r_rd_idx      <= n_rd_idx;
            r_mod_idx     <= n_mod_idx;
            r_rd_pend     <= n_rd_pend;
            r_grad        <= n_grad;
            r_rot_inc     <= n_rot_inc;
            r_rot_last    <= n_rot_last;
            r_out_valid   <= n_out_valid;
            r_out_status  <= n_out_status;
            r_out_idx     <= n_out_idx;
            r_out_red     <= n_out_red;
            r_out_green   <= n_out_green;
            r_out_blue    <= n_out_blue;
            r_out_last    <= n_out_last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.led_index = r_out_idx;
    assign o_res.red       = r_out_red;
    assign o_res.green     = r_out_green;
    assign o_res.blue      = r_out_blue;
    assign o_res.last      = r_out_last;

    assign w_tick_acc = w_cmd_acc && (i_cmd.cmd == CMD_TICK);
    assign w_res_end  = o_res.valid && o_res.last && !o_res.status;
    assign w_res_top  = (o_res.led_index == 6'(NUM_LEDS - 1));
    assign w_res_err  = o_res.valid && o_res.status;
    assign w_res_dark = o_res.last && (o_res.led_index == '0) &&
                        ({o_res.red, o_res.green, o_res.blue} == '0);

    // a pending memory read only exists inside a frame walk
    `LRAE_ASSERT_IMP(a_pend_in_walk, i_clk, i_rst_n, r_rd_pend, r_state == S_WALK)
    // the closing pixel of a frame is the highest led
    `LRAE_ASSERT_IMP(a_last_pixel_idx, i_clk, i_rst_n, w_res_end, w_res_top)
    // an error transaction is a lone dark result
    `LRAE_ASSERT_IMP(a_error_shape, i_clk, i_rst_n, w_res_err, w_res_dark)
    // every tick walks the frame
    `LRAE_ASSERT_NEXT(a_tick_walks, i_clk, i_rst_n, w_tick_acc, r_state == S_WALK)

endmodule
